// ===== rtl/core/kplt_pkg.sv =====
// shared types, codes and sizes for the keyed pin lease table
`default_nettype none

package kplt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 64;
    localparam int PIN_W       = 64;
    localparam int GEN_W       = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;

    localparam logic [MODE_W-1:0] MODE_PUBLISH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_EVICT   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  residency_key;
        logic [DATA_W-1:0] entry_payload;
        logic [IDX_W-1:0]  lease_slot;
        logic [PIN_W-1:0]  lease_pin_mask;
        logic [GEN_W-1:0]  lease_generation;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] result_status;
        logic [IDX_W-1:0]    granted_slot;
        logic [PIN_W-1:0]    granted_pin_mask;
        logic [GEN_W-1:0]    granted_generation;
        logic [DATA_W-1:0]   found_payload;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  entry_key;
        logic [DATA_W-1:0] entry_data;
        logic [PIN_W-1:0]  entry_pins;
        logic [GEN_W-1:0]  entry_generation;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic read;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic early_reject;
        logic is_publish;
        logic is_release;
        logic scan_done;
        logic scan_match;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/keyed_pin_lease_table.sv =====
// top level of the keyed pin lease table
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------
//   input    | in_valid / in_ready   | in_item  (kplt_pkg::in_item_t)
//   output   | out_valid / out_ready | out_item (kplt_pkg::out_item_t)
//   config   | cfg_we                | cfg_wdata (table_size)
//
// one item at a time; publish, acquire and evict scan the entry ram one slot
// per cycle over at most min(table_size, 64) slots; release reads only its lease slot
// a rejected item (zero key, zero table size, bad lease) skips the scan and read
// reset clears the occupancy bits and generation counter and sets the table size to 64
// a finished result waits in the output register while the next item is taken

`default_nettype none

module keyed_pin_lease_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  kplt_pkg::in_item_t         in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output kplt_pkg::out_item_t        out_item,
    input  logic                       cfg_we,
    input  logic [kplt_pkg::CNT_W-1:0] cfg_wdata
);
    import kplt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kplt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kplt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/kplt_datapath.sv =====
// entry memory, occupancy bits, key scan, update logic and result register
`default_nettype none

module kplt_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [kplt_pkg::CNT_W-1:0] cfg_wdata,
    input  kplt_pkg::in_item_t         in_item,
    input  kplt_pkg::dp_cmd_t          cmd,
    output kplt_pkg::dp_stat_t         stat,
    input  logic                       out_ready,
    output logic                       out_valid,
    output kplt_pkg::out_item_t        out_item
);
    import kplt_pkg::*;

    logic [CNT_W-1:0]       table_size_reg;
    in_item_t               item_reg;
    logic [CNT_W-1:0]       issue_idx_reg;
    logic                   chk_valid_reg;
    logic [IDX_W-1:0]       chk_idx_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic                   have_free_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic [TABLE_DEPTH-1:0] occupied_reg;
    logic [GEN_W-1:0]       gen_cnt_reg;
    entry_t                 mem [TABLE_DEPTH];
    entry_t                 rd_data_reg;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;

    logic [CNT_W-1:0] n_live;
    logic [PIN_W-1:0] mask_dec;
    logic             onehot_ok;
    logic             slot_ok;
    logic             early_reject;
    logic             scan_match;
    logic             free_hit;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] tgt_idx;
    logic [GEN_W-1:0] gen_use;
    logic [PIN_W-1:0] pins_inc;
    logic [PIN_W-1:0] grant_bit;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_word;
    logic             occ_set;
    logic             occ_clr;
    logic             gen_take;
    out_item_t        res;

    assign n_live = (table_size_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : table_size_reg;
    assign mask_dec  = item_reg.lease_pin_mask - PIN_W'(1);
    assign onehot_ok = (item_reg.lease_pin_mask != '0)
                    && ((item_reg.lease_pin_mask & mask_dec) == '0);
    assign slot_ok   = CNT_W'(item_reg.lease_slot) < n_live;

    assign early_reject = (n_live == '0) || (item_reg.residency_key == '0)
                       || ((item_reg.mode == MODE_RELEASE) && !(slot_ok && onehot_ok));

    assign scan_match = chk_valid_reg && occupied_reg[chk_idx_reg]
                     && (rd_data_reg.entry_key == item_reg.residency_key);
    assign free_hit   = chk_valid_reg && !occupied_reg[chk_idx_reg];

    assign tgt_idx = (item_reg.mode == MODE_RELEASE) ? item_reg.lease_slot : hit_idx_reg;
    assign rd_addr = cmd.read ? tgt_idx : issue_idx_reg[IDX_W-1:0];

    assign stat.early_reject = early_reject;
    assign stat.is_publish   = (item_reg.mode == MODE_PUBLISH);
    assign stat.is_release   = (item_reg.mode == MODE_RELEASE);
    assign stat.scan_done    = scan_match || (issue_idx_reg >= n_live);
    assign stat.scan_match   = scan_match;
    assign stat.out_free     = !out_valid_reg || out_ready;

    // generation zero is never handed out
    assign gen_use   = (gen_cnt_reg == '0) ? GEN_W'(1) : gen_cnt_reg;
    assign pins_inc  = rd_data_reg.entry_pins + PIN_W'(1);
    assign grant_bit = ~rd_data_reg.entry_pins & pins_inc;

    always_comb
    begin
        wr_en             = 1'b0;
        wr_idx            = tgt_idx;
        wr_word           = rd_data_reg;
        occ_set           = 1'b0;
        occ_clr           = 1'b0;
        gen_take          = 1'b0;
        res               = '0;
        res.result_status = ST_INVALID;
        if (!early_reject)
        begin
            case (item_reg.mode)
                MODE_PUBLISH:
                begin
                    if (hit_reg)
                    begin
                        res.result_status = ST_INVALID;
                    end
                    else if (!have_free_reg)
                    begin
                        res.result_status = ST_FULL;
                    end
                    else
                    begin
                        wr_en                    = 1'b1;
                        wr_idx                   = free_idx_reg;
                        wr_word.entry_key        = item_reg.residency_key;
                        wr_word.entry_data       = item_reg.entry_payload;
                        wr_word.entry_pins       = '0;
                        wr_word.entry_generation = gen_use;
                        occ_set                  = 1'b1;
                        gen_take                 = 1'b1;
                        res.result_status        = ST_OK;
                    end
                end
                MODE_ACQUIRE:
                begin
                    if (!hit_reg)
                    begin
                        res.result_status = ST_MISSING;
                    end
                    else if (&rd_data_reg.entry_pins)
                    begin
                        res.result_status = ST_FULL;
                    end
                    else
                    begin
                        wr_en                  = 1'b1;
                        wr_word.entry_pins     = rd_data_reg.entry_pins | grant_bit;
                        res.result_status      = ST_OK;
                        res.granted_slot       = hit_idx_reg;
                        res.granted_pin_mask   = grant_bit;
                        res.granted_generation = rd_data_reg.entry_generation;
                        res.found_payload      = rd_data_reg.entry_data;
                    end
                end
                MODE_RELEASE:
                begin
                    if (occupied_reg[item_reg.lease_slot]
                        && (rd_data_reg.entry_generation == item_reg.lease_generation)
                        && (rd_data_reg.entry_key == item_reg.residency_key)
                        && ((rd_data_reg.entry_pins & item_reg.lease_pin_mask) != '0))
                    begin
                        wr_en              = 1'b1;
                        wr_word.entry_pins = rd_data_reg.entry_pins
                                           & ~item_reg.lease_pin_mask;
                        res.result_status  = ST_OK;
                    end
                end
                default:
                begin
                    if (!hit_reg)
                    begin
                        res.result_status = ST_MISSING;
                    end
                    else if (rd_data_reg.entry_pins != '0)
                    begin
                        res.result_status = ST_BUSY;
                    end
                    else
                    begin
                        occ_clr           = 1'b1;
                        res.result_status = ST_OK;
                    end
                end
            endcase
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.update && wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        if (cmd.scan || cmd.read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.update)
        begin
            out_item_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= CNT_W'(TABLE_DEPTH);
            occupied_reg   <= '0;
            gen_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            issue_idx_reg  <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            have_free_reg  <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_size_reg <= cfg_wdata;
            end

            if (cmd.capture)
            begin
                issue_idx_reg <= '0;
                chk_valid_reg <= 1'b0;
                hit_reg       <= 1'b0;
                have_free_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_valid_reg <= (issue_idx_reg < n_live);
                chk_idx_reg   <= issue_idx_reg[IDX_W-1:0];
                if (issue_idx_reg < n_live)
                begin
                    issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                end
                if (scan_match)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= chk_idx_reg;
                end
                if (free_hit && !have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_idx_reg  <= chk_idx_reg;
                end
            end

            if (cmd.update)
            begin
                if (occ_set)
                begin
                    occupied_reg[wr_idx] <= 1'b1;
                end
                if (occ_clr)
                begin
                    occupied_reg[wr_idx] <= 1'b0;
                end
                if (gen_take)
                begin
                    gen_cnt_reg <= gen_use + GEN_W'(1);
                end
            end

            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/kplt_ctrl.sv =====
// operation sequencer: capture, check, key scan, entry read, update
`default_nettype none

module kplt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kplt_pkg::dp_stat_t stat,
    output kplt_pkg::dp_cmd_t  cmd
);
    import kplt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.early_reject)
                begin
                    state_next = S_UPDATE;
                end
                else if (stat.is_release)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    // publish needs no entry read: a hit means duplicate
                    if (stat.scan_match && !stat.is_publish)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kplt_checker.sv =====
// port-level assertions for the keyed pin lease table and their bind
`default_nettype none

module kplt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input kplt_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_ready,
    input kplt_pkg::out_item_t out_item
);
    import kplt_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.result_status != ST_OK) |->
            (out_item.granted_pin_mask == '0) && (out_item.granted_slot == '0)
            && (out_item.granted_generation == '0) && (out_item.found_payload == '0))
        else $error("failed item carries grant fields");

    a_grant_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.granted_pin_mask != '0) |->
            $onehot(out_item.granted_pin_mask) && (out_item.granted_generation != '0)
            && (out_item.result_status == ST_OK))
        else $error("bad pin grant");

endmodule

bind keyed_pin_lease_table kplt_checker u_kplt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire

// ===== tb/kplt_lease_ledger_pkg.sv =====
// lease table ledger: mirrors the entry table and checks the results it returns
`timescale 1ns / 1ps

package kplt_lease_ledger_pkg;

    import kplt_pkg::*;

    typedef logic [KEY_W-1:0] key_list_t[$];

    class lease_ledger;
        bit                occupied [TABLE_DEPTH];
        bit                written  [TABLE_DEPTH];
        logic [KEY_W-1:0]  keys     [TABLE_DEPTH];
        logic [DATA_W-1:0] data     [TABLE_DEPTH];
        logic [PIN_W-1:0]  pins     [TABLE_DEPTH];
        logic [GEN_W-1:0]  gens     [TABLE_DEPTH];
        logic [GEN_W-1:0]  gen_counter;
        logic [CNT_W-1:0]  table_size;
        out_item_t         pending_results[$];
        int                mismatch_count;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                occupied[i] = 1'b0;
                written[i]  = 1'b0;
                keys[i]     = '0;
                data[i]     = '0;
                pins[i]     = '0;
                gens[i]     = '0;
            end
            gen_counter    = '0;
            table_size     = CNT_W'(TABLE_DEPTH);
            mismatch_count = 0;
        endfunction

        function int live_size();
            return (int'(table_size) > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
        endfunction

        function key_list_t live_keys();
            key_list_t found;
            for (int i = 0; i < live_size(); i++)
            begin
                if (occupied[i])
                begin
                    found.push_back(keys[i]);
                end
            end
            return found;
        endfunction

        function void set_table_size(logic [CNT_W-1:0] value);
            table_size = value;
        endfunction

        // zero is never handed out as a generation
        function logic [GEN_W-1:0] next_generation();
            logic [GEN_W-1:0] g;
            g = gen_counter;
            gen_counter = g + 1'b1;
            if (g == '0)
            begin
                g = gen_counter;
                gen_counter = g + 1'b1;
            end
            return g;
        endfunction

        function out_item_t apply_table_op(in_item_t it);
            out_item_t        r;
            int               n;
            int               free_at;
            int               s;
            bit               dup;
            logic [PIN_W-1:0] p;
            logic [PIN_W-1:0] pin;
            r = '0;
            n = live_size();
            if (n == 0 || it.residency_key == '0)
            begin
                r.result_status = ST_INVALID;
                return r;
            end
            case (it.mode)
                MODE_PUBLISH:
                begin
                    free_at = -1;
                    dup = 1'b0;
                    for (int i = 0; i < n; i++)
                    begin
                        if (occupied[i] && keys[i] == it.residency_key)
                        begin
                            dup = 1'b1;
                            break;
                        end
                        if (!occupied[i] && free_at < 0)
                        begin
                            free_at = i;
                        end
                    end
                    if (dup)
                    begin
                        r.result_status = ST_INVALID;
                    end
                    else if (free_at < 0)
                    begin
                        r.result_status = ST_FULL;
                    end
                    else
                    begin
                        keys[free_at]     = it.residency_key;
                        data[free_at]     = it.entry_payload;
                        pins[free_at]     = '0;
                        gens[free_at]     = next_generation();
                        occupied[free_at] = 1'b1;
                        written[free_at]  = 1'b1;
                        r.result_status   = ST_OK;
                    end
                end
                MODE_ACQUIRE:
                begin
                    r.result_status = ST_MISSING;
                    for (int i = 0; i < n; i++)
                    begin
                        if (occupied[i] && keys[i] == it.residency_key)
                        begin
                            p = pins[i];
                            if (p == '1)
                            begin
                                r.result_status = ST_FULL;
                            end
                            else
                            begin
                                pin = ~p & (p + 1'b1);
                                pins[i] = p | pin;
                                r.result_status      = ST_OK;
                                r.granted_slot       = IDX_W'(i);
                                r.granted_pin_mask   = pin;
                                r.granted_generation = gens[i];
                                r.found_payload      = data[i];
                            end
                            break;
                        end
                    end
                end
                MODE_RELEASE:
                begin
                    r.result_status = ST_INVALID;
                    s = int'(it.lease_slot);
                    if (s < n && it.lease_pin_mask != '0 &&
                        (it.lease_pin_mask & (it.lease_pin_mask - 1'b1)) == '0)
                    begin
                        if (occupied[s] && gens[s] == it.lease_generation &&
                            keys[s] == it.residency_key && (pins[s] & it.lease_pin_mask) != '0)
                        begin
                            pins[s] = pins[s] & ~it.lease_pin_mask;
                            r.result_status = ST_OK;
                        end
                    end
                end
                default:
                begin
                    r.result_status = ST_MISSING;
                    for (int i = 0; i < n; i++)
                    begin
                        if (occupied[i] && keys[i] == it.residency_key)
                        begin
                            if (pins[i] != '0)
                            begin
                                r.result_status = ST_BUSY;
                            end
                            else
                            begin
                                occupied[i] = 1'b0;
                                keys[i] = '0;
                                data[i] = '0;
                                r.result_status = ST_OK;
                            end
                            break;
                        end
                    end
                end
            endcase
            return r;
        endfunction

        function void note_request(in_item_t it);
            pending_results.push_back(apply_table_op(it));
        endfunction

        function void check_response(out_item_t got);
            out_item_t want;
            bit        bad;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: result with no item pending, status %0d",
                             $time, got.result_status);
                end
                return;
            end
            want = pending_results.pop_front();
            bad = (got.result_status !== want.result_status) ||
                  (got.granted_slot !== want.granted_slot) ||
                  (got.granted_pin_mask !== want.granted_pin_mask) ||
                  (got.granted_generation !== want.granted_generation) ||
                  (got.found_payload !== want.found_payload);
            if (bad)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: mismatch expected st=%0d slot=%0d pin=%h gen=%h data=%h",
                             $time, want.result_status, want.granted_slot,
                             want.granted_pin_mask, want.granted_generation,
                             want.found_payload);
                    $display("%0t:          actual   st=%0d slot=%0d pin=%h gen=%h data=%h",
                             $time, got.result_status, got.granted_slot,
                             got.granted_pin_mask, got.granted_generation,
                             got.found_payload);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_keyed_pin_lease_table.sv =====
// testbench for the keyed pin lease table: directed and random table operations
`timescale 1ns / 1ps

module tb_keyed_pin_lease_table;

    import kplt_pkg::*;
    import kplt_lease_ledger_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;

    lease_ledger          ledger = new();
    logic [KEY_W-1:0]     key_pool[$];
    bit                   hold_off_req = 1'b0;
    bit                   quiet_tail = 1'b0;

    int phase_size   [8] = '{4, 1, 0, 127, 33, 2, 64, 100};
    int phase_items  [8] = '{150, 130, 40, 200, 150, 130, 200, 110};
    int phase_pool   [8] = '{12, 2, 8, 40, 30, 3, 20, 24};
    bit phase_hammer [8] = '{0, 1, 0, 0, 0, 1, 0, 0};

    keyed_pin_lease_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_item_t op_item(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                         logic [DATA_W-1:0] payload, int slot,
                                         logic [PIN_W-1:0] mask, logic [GEN_W-1:0] gen);
        in_item_t it;
        it.mode             = mode;
        it.residency_key    = key;
        it.entry_payload    = payload;
        it.lease_slot       = IDX_W'(slot);
        it.lease_pin_mask   = mask;
        it.lease_generation = gen;
        return it;
    endfunction

    function automatic in_item_t random_item();
        return op_item(MODE_W'($urandom_range(0, 3)), $urandom(), {$urandom(), $urandom()},
                       $urandom_range(0, TABLE_DEPTH - 1), {$urandom(), $urandom()},
                       $urandom());
    endfunction

    function automatic void refill_pool(int fresh);
        key_pool = ledger.live_keys();
        repeat (fresh) key_pool.push_back($urandom());
        if ($urandom_range(0, 1) == 0)
        begin
            key_pool.push_back('1);
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(bit prefer_live);
        key_list_t live;
        live = ledger.live_keys();
        if ($urandom_range(0, 99) < 3)
        begin
            return '0;
        end
        if (prefer_live && live.size() != 0 && $urandom_range(0, 9) != 0)
        begin
            return live[$urandom_range(0, live.size() - 1)];
        end
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // never name an in-range slot that has not been written yet
    function automatic in_item_t legal_slot(in_item_t it);
        int n;
        n = ledger.live_size();
        if (it.mode == MODE_RELEASE && int'(it.lease_slot) < n && !ledger.written[it.lease_slot])
        begin
            if (n < TABLE_DEPTH)
            begin
                it.lease_slot = IDX_W'($urandom_range(n, TABLE_DEPTH - 1));
            end
            else
            begin
                it.mode = MODE_ACQUIRE;
            end
        end
        return it;
    endfunction

    // a lease on a held pin, now and then spoiled in one way
    function automatic in_item_t lease_release();
        in_item_t it;
        int       cand[$];
        int       held[$];
        int       clear[$];
        int       n;
        int       s;
        int       j;
        it = random_item();
        it.mode = MODE_RELEASE;
        n = ledger.live_size();
        for (s = 0; s < n; s++)
        begin
            if (ledger.occupied[s] && ledger.pins[s] != '0)
            begin
                cand.push_back(s);
            end
        end
        if (cand.size() == 0)
        begin
            it.residency_key = pick_key(1'b1);
            return it;
        end
        s = cand[$urandom_range(0, cand.size() - 1)];
        for (j = 0; j < PIN_W; j++)
        begin
            if (ledger.pins[s][j])
            begin
                held.push_back(j);
            end
            else
            begin
                clear.push_back(j);
            end
        end
        it.residency_key    = ledger.keys[s];
        it.lease_slot       = IDX_W'(s);
        it.lease_generation = ledger.gens[s];
        it.lease_pin_mask   = '0;
        it.lease_pin_mask[held[$urandom_range(0, held.size() - 1)]] = 1'b1;
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    j = $urandom_range(0, GEN_W - 1);
                    it.lease_generation[j] = ~it.lease_generation[j];
                end
                1:
                begin
                    j = $urandom_range(0, KEY_W - 1);
                    it.residency_key[j] = ~it.residency_key[j];
                end
                2: it.lease_pin_mask[$urandom_range(0, PIN_W - 1)] = 1'b1;
                3: it.lease_pin_mask = '0;
                4:
                begin
                    if (clear.size() != 0)
                    begin
                        it.lease_pin_mask = '0;
                        it.lease_pin_mask[clear[$urandom_range(0, clear.size() - 1)]] = 1'b1;
                    end
                end
                default:
                begin
                    if (n < TABLE_DEPTH)
                    begin
                        it.lease_slot = IDX_W'($urandom_range(n, TABLE_DEPTH - 1));
                    end
                end
            endcase
        end
        return it;
    endfunction

    function automatic in_item_t next_request(bit hammer);
        in_item_t it;
        int       r;
        it = random_item();
        r = $urandom_range(0, 99);
        if (r < (hammer ? 6 : 25))
        begin
            it.mode = MODE_PUBLISH;
            it.residency_key = pick_key(1'b0);
        end
        else if (r < (hammer ? 86 : 58))
        begin
            it.mode = MODE_ACQUIRE;
            it.residency_key = pick_key(1'b1);
        end
        else if (r < (hammer ? 94 : 80))
        begin
            it = lease_release();
        end
        else if (r < (hammer ? 97 : 90))
        begin
            it.mode = MODE_EVICT;
            it.residency_key = pick_key(1'b1);
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            it.residency_key = pick_key(1'b0);
        end
        return legal_slot(it);
    endfunction

    task automatic send_item(in_item_t it);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_request(it);
        @(negedge clk);
    endtask

    task automatic set_table_size(int value);
        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        ledger.set_table_size(CNT_W'(value));
    endtask

    task automatic run_random(int count, bit hammer);
        repeat (count) send_item(next_request(hammer));
    endtask

    task automatic run_directed();
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        ka = 32'h0000_0001;
        kb = 32'hFFFF_FFFF;
        send_item(op_item(MODE_PUBLISH, '0, '1, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_ACQUIRE, '0, '0, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_EVICT, '0, '0, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_ACQUIRE, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_EVICT, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_PUBLISH, ka, '1, 0, '0, '0));
        send_item(op_item(MODE_PUBLISH, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_PUBLISH, kb, '0, 0, '0, '0));
        send_item(op_item(MODE_RELEASE, '0, '0, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_ACQUIRE, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_ACQUIRE, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_EVICT, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, 64'h3, 32'h1));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, '0, 32'h1));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, 64'h2, 32'h2));
        send_item(op_item(MODE_RELEASE, kb, '0, 0, 64'h2, 32'h1));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, 64'h2, 32'h1));
        send_item(op_item(MODE_EVICT, ka, '0, 0, '0, '0));
        send_item(op_item(MODE_RELEASE, ka, '0, 0, 64'h1, 32'h1));
        send_item(op_item(MODE_PUBLISH, 32'h5A5A_1234, 64'h8000_0000_0000_0001, 0, '0, '0));
        send_item(op_item(MODE_ACQUIRE, kb, '0, 0, '0, '0));
        send_item(op_item(MODE_RELEASE, kb, '0, 1, 64'h8000_0000_0000_0000, 32'h2));
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            ledger.check_response(out_item);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        refill_pool(20);
        run_directed();
        run_random(250, 1'b0);
        for (int p = 0; p < 8; p++)
        begin
            set_table_size(phase_size[p]);
            if (p == 3)
            begin
                hold_off_req = 1'b1;
            end
            if (p == 7)
            begin
                quiet_tail = 1'b1;
            end
            refill_pool(phase_pool[p]);
            run_random(phase_items[p], phase_hammer[p]);
        end
        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (ledger.mismatch_count == 0 && ledger.pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== keyed_pin_lease_table.f =====
rtl/core/kplt_pkg.sv
rtl/core/kplt_datapath.sv
rtl/core/kplt_ctrl.sv
rtl/core/keyed_pin_lease_table.sv
rtl/core/kplt_checker.sv
tb/kplt_lease_ledger_pkg.sv
tb/tb_keyed_pin_lease_table.sv
